>>> hdl/eqc_pkg.sv
// Shared constants, transaction types and tables for the cubemap sampler.
`default_nettype none

package eqc_pkg;

    // Parameter defaults
    localparam int DEF_MAX_SRC_WIDTH  = 512;
    localparam int DEF_MAX_SRC_HEIGHT = 256;
    localparam int DEF_MAX_FACE       = 512;
    localparam int FACE_MIN           = 16;

    // Register reset values and indexes
    localparam logic [9:0] WIDTH_RESET    = 10'd512;
    localparam logic [8:0] HEIGHT_RESET   = 9'd256;
    localparam logic       REG_SRC_WIDTH  = 1'b0;
    localparam logic       REG_SRC_HEIGHT = 1'b1;

    // Opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Face codes
    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    // Arithmetic constants
    localparam logic [15:0] INV_GAIN     = 16'd39797;
    localparam int          CORDIC_STEPS = 14;
    localparam int          DIV_STEPS    = 17;

    // Pipeline stage map
    localparam int ST_DIR   = DIV_STEPS;
    localparam int ST_C1    = ST_DIR + 1;
    localparam int ST_RC    = ST_C1 + CORDIC_STEPS;
    localparam int ST_C2    = ST_RC + 1;
    localparam int ST_TEX   = ST_C2 + CORDIC_STEPS;
    localparam int ST_WGT   = ST_TEX + 1;
    localparam int ST_ADR   = ST_WGT + 1;
    localparam int N_STAGES = ST_ADR + 2;

    // Arctangent of 2^-i in 2^-16 turn
    function automatic logic signed [17:0] atan_step(input int i);
        logic signed [17:0] r;
        case (i)
            0:       r = 18'sd8192;
            1:       r = 18'sd4836;
            2:       r = 18'sd2555;
            3:       r = 18'sd1297;
            4:       r = 18'sd651;
            5:       r = 18'sd326;
            6:       r = 18'sd163;
            7:       r = 18'sd81;
            8:       r = 18'sd41;
            9:       r = 18'sd20;
            10:      r = 18'sd10;
            11:      r = 18'sd5;
            12:      r = 18'sd3;
            13:      r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // Channel transactions
    typedef struct packed {
        logic        opcode;
        logic [8:0]  src_col;
        logic [7:0]  src_row;
        logic [15:0] texel_red;
        logic [15:0] texel_green;
        logic [15:0] texel_blue;
        logic [15:0] texel_alpha;
        logic [2:0]  face_sel;
        logic [6:0]  face_col;
        logic [6:0]  face_row;
    } item_t;

    typedef struct packed {
        logic [15:0] sample_red;
        logic [15:0] sample_green;
        logic [15:0] sample_blue;
        logic [15:0] sample_alpha;
        logic        status;
    } result_t;

    typedef struct packed {
        logic       reg_index;
        logic [9:0] reg_value;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/eqc_stream_if.sv
// Valid/ready channel interface with a typed payload.
`default_nettype none

interface eqc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/eqc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module eqc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read-first registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

`default_nettype wire

>>> hdl/equirect_to_cubemap_sampler.sv
// Top level: equirectangular source store and bilinear cubemap sampler.
//
//  channel  dir   payload            accepted when
//  cfg      in    eqc_pkg::cfg_t     cfg.valid & cfg.ready (ready always high)
//  item     in    eqc_pkg::item_t    item.valid & item.ready
//  result   out   eqc_pkg::result_t  result.valid & result.ready
//
// A sample request occupies the texel memory port for four texel reads, and the next
// request is taken no earlier than its last read; a texel write takes one access.
// A request passes a 51-stage front pipeline (divider, two CORDICs, weights,
// addresses), then reads, products and accumulation.
// Reset clears control only; the texel memory is not cleared.
// A stalled result side holds the pipeline once two results are owed.
`default_nettype none

module equirect_to_cubemap_sampler #(
    parameter int MAX_SRC_WIDTH  = eqc_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = eqc_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_FACE       = eqc_pkg::DEF_MAX_FACE
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    eqc_stream_if.sink   cfg,
    eqc_stream_if.sink   item,
    eqc_stream_if.source result
);
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int WEW   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HEW   = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int NW    = $clog2(MAX_FACE + 1);
    localparam int BXW   = 16 + WEW;
    localparam int BYW   = 17 + HEW;
    localparam int LAST  = eqc_pkg::N_STAGES - 1;

    typedef struct packed {
        logic [WEW-1:0] w;
        logic [WEW-1:0] wm;
        logic [HEW-1:0] h;
        logic [HEW-1:0] hm;
        logic [NW-1:0]  n;
    } geom_t;

    typedef struct packed {
        logic                     is_req;
        logic                     status;
        logic [2:0]               face;
        logic [6:0]               col;
        logic [6:0]               row;
        logic                     wr_ok;
        logic [63:0]              wdata;
        logic [23:0]              rem_u;
        logic [23:0]              rem_v;
        logic [16:0]              q_u;
        logic [16:0]              q_v;
        logic signed [19:0]       cx;
        logic signed [19:0]       cy;
        logic signed [17:0]       cang;
        logic signed [19:0]       dy;
        logic signed [17:0]       phi;
        logic [15:0]              su;
        logic [16:0]              sv;
        logic [BXW-1:0]           bx;
        logic [BYW-1:0]           by;
        logic [XW-1:0]            x0;
        logic [XW-1:0]            x1;
        logic [YW-1:0]            y0;
        logic [YW-1:0]            y1;
        logic [3:0][32:0]         wgt;
        logic [3:0][AW-1:0]       addr;
    } pipe_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_READ = 2'b10
    } seq_state_t;

    // Derived geometry from the size registers
    function automatic geom_t geom_of(input logic [9:0] wr, input logic [8:0] hr);
        int    w;
        int    h;
        int    n;
        geom_t g;
        w = int'(wr);
        h = int'(hr);
        if (w < 1) w = 1;
        if (w > MAX_SRC_WIDTH) w = MAX_SRC_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_SRC_HEIGHT) h = MAX_SRC_HEIGHT;
        n = ((w >> 2) < (h >> 1)) ? (w >> 2) : (h >> 1);
        if (n < eqc_pkg::FACE_MIN) n = eqc_pkg::FACE_MIN;
        if (n > MAX_FACE) n = MAX_FACE;
        g.w  = WEW'(w);
        g.wm = WEW'((w > 1) ? w - 1 : 1);
        g.h  = HEW'(h);
        g.hm = HEW'((h > 1) ? h - 1 : 1);
        g.n  = NW'(n);
        return g;
    endfunction

    // Work of one front pipeline stage
    function automatic pipe_t stage_step(input int s, input pipe_t p, input geom_t g);
        pipe_t              o;
        logic [31:0]        dsh;
        logic signed [17:0] a;
        logic signed [17:0] b;
        logic signed [19:0] dx;
        logic signed [19:0] dyv;
        logic signed [19:0] dz;
        logic signed [19:0] xs;
        logic signed [19:0] ys;
        logic [35:0]        rprod;
        logic signed [19:0] rc;
        logic signed [18:0] svs;
        logic [WEW-1:0]     x0f;
        logic [WEW-1:0]     wmax;
        logic [HEW:0]       y0f;
        logic [HEW:0]       hmax;
        logic [16:0]        ix;
        logic [16:0]        iy;
        logic [16:0]        tx;
        logic [16:0]        ty;
        int                 i;
        o = p;
        if (s < eqc_pkg::ST_DIR)
        begin
            // One restoring-division bit for u and v
            if (s == 0)
            begin
                o.status = (32'(p.col) >= 32'(g.n)) || (32'(p.row) >= 32'(g.n));
            end
            dsh = 32'(g.n) << (eqc_pkg::DIV_STEPS - 1 - s);
            if (32'(p.rem_u) >= dsh)
            begin
                o.rem_u = 24'(32'(p.rem_u) - dsh);
                o.q_u[eqc_pkg::DIV_STEPS - 1 - s] = 1'b1;
            end
            if (32'(p.rem_v) >= dsh)
            begin
                o.rem_v = 24'(32'(p.rem_v) - dsh);
                o.q_v[eqc_pkg::DIV_STEPS - 1 - s] = 1'b1;
            end
        end
        else if (s == eqc_pkg::ST_DIR)
        begin
            // Face direction, then half-turn pre-rotation for atan2(z, x)
            a = $signed({1'b0, p.q_u}) - 18'sd65536;
            b = 18'sd65536 - $signed({1'b0, p.q_v});
            unique case (p.face)
                eqc_pkg::FACE_PX: begin dx = 20'sd65536;  dyv = 20'(b);       dz = -(20'(a)); end
                eqc_pkg::FACE_NX: begin dx = -20'sd65536; dyv = 20'(b);       dz = 20'(a);    end
                eqc_pkg::FACE_PY: begin dx = 20'(a);      dyv = 20'sd65536;   dz = -(20'(b)); end
                eqc_pkg::FACE_NY: begin dx = 20'(a);      dyv = -20'sd65536;  dz = 20'(b);    end
                eqc_pkg::FACE_PZ: begin dx = 20'(a);      dyv = 20'(b);       dz = 20'sd65536; end
                eqc_pkg::FACE_NZ: begin dx = -(20'(a));   dyv = 20'(b);       dz = -20'sd65536; end
                default:          begin dx = 20'sd0;      dyv = 20'sd0;       dz = 20'sd65536; end
            endcase
            o.dy = dyv;
            if (dx < 0)
            begin
                o.cang = (dz >= 0) ? 18'sd32768 : -18'sd32768;
                o.cx   = -dx;
                o.cy   = -dz;
            end
            else
            begin
                o.cang = 18'sd0;
                o.cx   = dx;
                o.cy   = dz;
            end
        end
        else if ((s >= eqc_pkg::ST_C1 && s < eqc_pkg::ST_RC) ||
                 (s >= eqc_pkg::ST_C2 && s < eqc_pkg::ST_TEX))
        begin
            // One CORDIC vectoring iteration
            i  = (s < eqc_pkg::ST_RC) ? s - eqc_pkg::ST_C1 : s - eqc_pkg::ST_C2;
            xs = p.cx >>> i;
            ys = p.cy >>> i;
            if (p.cy < 0)
            begin
                o.cx   = p.cx - ys;
                o.cy   = p.cy + xs;
                o.cang = p.cang - eqc_pkg::atan_step(i);
            end
            else
            begin
                o.cx   = p.cx + ys;
                o.cy   = p.cy - xs;
                o.cang = p.cang + eqc_pkg::atan_step(i);
            end
        end
        else if (s == eqc_pkg::ST_RC)
        begin
            // Gain correction of the magnitude, start of the elevation CORDIC
            o.phi = p.cang;
            rprod = 36'($unsigned(p.cx)) * 36'(eqc_pkg::INV_GAIN) + 36'd32768;
            rc    = $signed(20'(rprod >> 16));
            if (rc < 0)
            begin
                o.cang = (p.dy >= 0) ? 18'sd32768 : -18'sd32768;
                o.cx   = -rc;
                o.cy   = -p.dy;
            end
            else
            begin
                o.cang = 18'sd0;
                o.cx   = rc;
                o.cy   = p.dy;
            end
        end
        else if (s == eqc_pkg::ST_TEX)
        begin
            // Texture coordinates and scaled sample positions
            o.su = 16'(p.phi + 18'sd32768);
            svs  = 19'sd32768 - (19'(p.cang) <<< 1);
            if (svs < 0)
            begin
                o.sv = 17'd0;
            end
            else if (svs > 19'sd65536)
            begin
                o.sv = 17'd65536;
            end
            else
            begin
                o.sv = 17'(svs);
            end
            o.bx = BXW'(BXW'(o.su) * BXW'(g.wm));
            o.by = BYW'(BYW'(o.sv) * BYW'(g.hm));
        end
        else if (s == eqc_pkg::ST_WGT)
        begin
            // Texel indices with wrap and clamp, bilinear weights
            wmax = g.w - WEW'(1);
            x0f  = WEW'(p.bx >> 16);
            if (x0f > wmax) x0f = wmax;
            o.x0 = XW'(x0f);
            o.x1 = (x0f == wmax) ? XW'(0) : XW'(x0f + WEW'(1));
            hmax = (HEW + 1)'(g.h) - (HEW + 1)'(1);
            y0f  = (HEW + 1)'(p.by >> 16);
            if (y0f > hmax) y0f = hmax;
            o.y0 = YW'(y0f);
            o.y1 = (y0f == hmax) ? YW'(hmax) : YW'(y0f + (HEW + 1)'(1));
            tx   = {1'b0, p.bx[15:0]};
            ty   = {1'b0, p.by[15:0]};
            ix   = 17'd65536 - tx;
            iy   = 17'd65536 - ty;
            o.wgt[0] = 33'(33'(ix) * 33'(iy));
            o.wgt[1] = 33'(33'(tx) * 33'(iy));
            o.wgt[2] = 33'(33'(ix) * 33'(ty));
            o.wgt[3] = 33'(33'(tx) * 33'(ty));
        end
        else if (s == eqc_pkg::ST_ADR)
        begin
            // Memory addresses of the four texels
            if (p.is_req)
            begin
                o.addr[0] = AW'(32'(p.y0) * MAX_SRC_WIDTH + 32'(p.x0));
                o.addr[1] = AW'(32'(p.y0) * MAX_SRC_WIDTH + 32'(p.x1));
                o.addr[2] = AW'(32'(p.y1) * MAX_SRC_WIDTH + 32'(p.x0));
                o.addr[3] = AW'(32'(p.y1) * MAX_SRC_WIDTH + 32'(p.x1));
            end
        end
        return o;
    endfunction

    logic [9:0]       width_reg;
    logic [8:0]       height_reg;
    geom_t            geom_reg;

    pipe_t            pipe_reg  [eqc_pkg::N_STAGES];
    pipe_t            pipe_next [eqc_pkg::N_STAGES];
    logic [LAST:0]    vld_reg;
    logic             adv;

    seq_state_t       seq_state_reg;
    seq_state_t       seq_state_next;
    logic [1:0]       phase_reg;
    logic [3:0][AW-1:0] seq_addr_reg;
    logic [3:0][32:0] seq_wgt_reg;
    logic             seq_stat_reg;
    logic             seq_busy;
    logic             seq_last;
    logic             take_wr;
    logic             take_rd;
    logic             credit_ok;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [63:0]      ram_rdata;

    logic             rd_vld_reg;
    logic             rd_first_reg;
    logic             rd_last_reg;
    logic             rd_stat_reg;
    logic [32:0]      rd_wgt_reg;

    logic             pr_vld_reg;
    logic             pr_first_reg;
    logic             pr_last_reg;
    logic             pr_stat_reg;
    logic [3:0][47:0] prod_reg;
    logic [3:0][47:0] acc_reg;
    logic [3:0][47:0] sum;
    logic [3:0][47:0] rnd;
    logic             push;
    logic             pop;

    eqc_pkg::result_t fifo_reg [2];
    eqc_pkg::result_t res_new;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fo_cnt_reg;
    logic [1:0]       flight_cnt_reg;
    logic [1:0]       flight_cnt_next;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= eqc_pkg::WIDTH_RESET;
            height_reg <= eqc_pkg::HEIGHT_RESET;
            geom_reg   <= geom_of(eqc_pkg::WIDTH_RESET, eqc_pkg::HEIGHT_RESET);
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.data.reg_index)
                    eqc_pkg::REG_SRC_WIDTH:  width_reg  <= cfg.data.reg_value;
                    eqc_pkg::REG_SRC_HEIGHT: height_reg <= cfg.data.reg_value[8:0];
                endcase
            end
            geom_reg <= geom_of(width_reg, height_reg);
        end
    end

    // Front pipeline: capture, then one step per stage
    assign item.ready = adv;

    always_comb
    begin
        pipe_next[0]        = '0;
        pipe_next[0].is_req = (item.data.opcode == eqc_pkg::OP_SAMPLE);
        pipe_next[0].face   = item.data.face_sel;
        pipe_next[0].col    = item.data.face_col;
        pipe_next[0].row    = item.data.face_row;
        pipe_next[0].wdata  = {item.data.texel_alpha, item.data.texel_blue,
                               item.data.texel_green, item.data.texel_red};
        pipe_next[0].wr_ok  = (32'(item.data.src_col) < MAX_SRC_WIDTH) &&
                              (32'(item.data.src_row) < MAX_SRC_HEIGHT);
        pipe_next[0].addr[0] = AW'(32'(item.data.src_row) * MAX_SRC_WIDTH +
                                   32'(item.data.src_col));
        pipe_next[0].rem_u  = {item.data.face_col, 1'b1, 16'd0};
        pipe_next[0].rem_v  = {item.data.face_row, 1'b1, 16'd0};
        for (int s = 0; s < LAST; s++)
        begin
            pipe_next[s + 1] = stage_step(s, pipe_reg[s], geom_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], item.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= LAST; s++)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    // Memory sequencer: one write or four reads per transaction
    assign seq_busy  = (seq_state_reg == SEQ_READ);
    assign seq_last  = seq_busy && (phase_reg == 2'd3);
    assign credit_ok = (flight_cnt_reg < 2'd2);
    assign take_wr   = vld_reg[LAST] && !pipe_reg[LAST].is_req && !seq_busy;
    assign take_rd   = vld_reg[LAST] && pipe_reg[LAST].is_req &&
                       (!seq_busy || seq_last) && credit_ok;
    assign adv       = !vld_reg[LAST] || take_wr || take_rd;

    always_comb
    begin
        seq_state_next = seq_state_reg;
        unique case (seq_state_reg)
            SEQ_IDLE: if (take_rd) seq_state_next = SEQ_READ;
            SEQ_READ: if (seq_last && !take_rd) seq_state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_IDLE;
            phase_reg     <= 2'd0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            phase_reg     <= take_rd ? 2'd0 : phase_reg + 2'(seq_busy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_rd)
        begin
            seq_addr_reg <= pipe_reg[LAST].addr;
            seq_wgt_reg  <= pipe_reg[LAST].wgt;
            seq_stat_reg <= pipe_reg[LAST].status;
        end
    end

    assign ram_we   = take_wr && pipe_reg[LAST].wr_ok;
    assign ram_addr = seq_busy ? seq_addr_reg[phase_reg] : pipe_reg[LAST].addr[0];

    eqc_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_texel_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pipe_reg[LAST].wdata),
        .rdata (ram_rdata)
    );

    // Read tag, products, accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            pr_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= seq_busy;
            pr_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_first_reg <= (phase_reg == 2'd0);
        rd_last_reg  <= (phase_reg == 2'd3);
        rd_stat_reg  <= seq_stat_reg;
        rd_wgt_reg   <= seq_wgt_reg[phase_reg];
        pr_first_reg <= rd_first_reg;
        pr_last_reg  <= rd_last_reg;
        pr_stat_reg  <= rd_stat_reg;
        for (int k = 0; k < 4; k++)
        begin
            prod_reg[k] <= rd_stat_reg ? 48'd0 :
                           48'(48'(ram_rdata[16*k +: 16]) * 48'(rd_wgt_reg));
        end
        if (pr_vld_reg)
        begin
            acc_reg <= sum;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum[k] = (pr_first_reg ? 48'd0 : acc_reg[k]) + prod_reg[k];
            rnd[k] = sum[k] + 48'h0000_8000_0000;
        end
        res_new.sample_red   = rnd[0][47:32];
        res_new.sample_green = rnd[1][47:32];
        res_new.sample_blue  = rnd[2][47:32];
        res_new.sample_alpha = rnd[3][47:32];
        res_new.status       = pr_stat_reg;
    end

    assign push = pr_vld_reg && pr_last_reg;
    assign pop  = result.valid && result.ready;

    // Result queue, two entries, sized by the request credit
    assign result.valid = (fo_cnt_reg != 2'd0);
    assign result.data  = fifo_reg[rd_ptr_reg];
    assign flight_cnt_next = flight_cnt_reg + 2'(take_rd) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            fo_cnt_reg     <= 2'd0;
            flight_cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg ^ push;
            rd_ptr_reg     <= rd_ptr_reg ^ pop;
            fo_cnt_reg     <= fo_cnt_reg + 2'(push) - 2'(pop);
            flight_cnt_reg <= flight_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res_new;
        end
    end

    // Checks
    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !seq_busy)
        else $error("texel write collides with a read sequence");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fo_cnt_reg != 2'd2 || pop))
        else $error("result queue overflow");

    a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        fo_cnt_reg <= flight_cnt_reg)
        else $error("queued results exceed outstanding requests");

    a_push_from_last_read: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $past(rd_vld_reg && rd_last_reg))
        else $error("result pushed without its fourth texel read");

    a_read_runs_four: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_busy && phase_reg != 2'd3) |=> seq_busy)
        else $error("read sequence ended early");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the equirectangular-to-cubemap sampler.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STORE_W     = eqc_pkg::DEF_MAX_SRC_WIDTH;
    localparam int  STORE_H     = eqc_pkg::DEF_MAX_SRC_HEIGHT;
    localparam int  ONE         = 65536;
    localparam int  HALF        = 32768;
    localparam int  SETTLE      = 80;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  PHASE_ITEMS = 215;
    localparam int  ITEM_W      = $bits(eqc_pkg::item_t);
    localparam int  ATAN_TURNS [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                        41, 20, 10, 5, 3, 1};

    // Bilinear tap positions for one request
    typedef struct {
        bit     flagged;
        int     x0, x1, y0, y1;
        longint tx, ty;
    } taps_t;

    // Directed stimulus row; want is used only when fixed is set
    typedef struct {
        eqc_pkg::item_t   it;
        bit               fixed;
        eqc_pkg::result_t want;
    } row_t;

    logic clk;
    logic rst_n;

    eqc_stream_if #(.T(eqc_pkg::cfg_t))    cfg_if ();
    eqc_stream_if #(.T(eqc_pkg::item_t))   item_if ();
    eqc_stream_if #(.T(eqc_pkg::result_t)) result_if ();

    equirect_to_cubemap_sampler uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .item   (item_if),
        .result (result_if)
    );

    // Predictor state
    logic [63:0]      image_mem [int];
    bit               loaded [int];
    logic [9:0]       width_reg  = eqc_pkg::WIDTH_RESET;
    logic [8:0]       height_reg = eqc_pkg::HEIGHT_RESET;
    eqc_pkg::result_t pending_samples [$];
    row_t             fixed_samples [$];

    int errors       = 0;
    int cycles       = 0;
    int n_writes     = 0;
    int n_requests   = 0;
    int n_flagged    = 0;
    int n_checked    = 0;
    int n_settings   = 0;
    bit src_calm     = 0;
    bit hold_done    = 0;
    int hold_left    = 0;
    int sink_gap     = 0;

    function automatic int eff_width();
        return (width_reg == 0) ? 1 : (width_reg > STORE_W) ? STORE_W : int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : (height_reg > STORE_H) ? STORE_H : int'(height_reg);
    endfunction

    // Vectoring CORDIC: angle of (x, y) in 2^-16 turn, gain-scaled magnitude out
    function automatic longint vector_angle(longint x, longint y, output longint mag);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        if (x < 0)
        begin
            ang = (y >= 0) ? HALF : -HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 14; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                ang -= ATAN_TURNS[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                ang += ATAN_TURNS[i];
            end
        end
        mag = x;
        return ang;
    endfunction

    // Face pixel -> four source texel positions and weights
    function automatic taps_t locate(logic [2:0] face, int col, int row, int w, int h);
        taps_t  t;
        int     n;
        longint a, b, dx, dy, dz, r, rc, phi, theta, dummy, su, svs, bx, by;
        int     wm, hm;
        t = '{default: 0};
        n = (w / 4 < h / 2) ? w / 4 : h / 2;
        if (n < eqc_pkg::FACE_MIN)
            n = eqc_pkg::FACE_MIN;
        if (n > eqc_pkg::DEF_MAX_FACE)
            n = eqc_pkg::DEF_MAX_FACE;
        if (col >= n || row >= n)
        begin
            t.flagged = 1;
            return t;
        end
        a = ((2 * longint'(col) + 1) * ONE) / n - ONE;
        b = ONE - ((2 * longint'(row) + 1) * ONE) / n;
        case (face)
            eqc_pkg::FACE_PX: begin dx = ONE;  dy = b;    dz = -a;   end
            eqc_pkg::FACE_NX: begin dx = -ONE; dy = b;    dz = a;    end
            eqc_pkg::FACE_PY: begin dx = a;    dy = ONE;  dz = -b;   end
            eqc_pkg::FACE_NY: begin dx = a;    dy = -ONE; dz = b;    end
            eqc_pkg::FACE_PZ: begin dx = a;    dy = b;    dz = ONE;  end
            eqc_pkg::FACE_NZ: begin dx = -a;   dy = b;    dz = -ONE; end
            default:          begin dx = 0;    dy = 0;    dz = ONE;  end
        endcase
        phi   = vector_angle(dx, dz, r);
        rc    = (r * longint'(eqc_pkg::INV_GAIN) + HALF) >>> 16;
        theta = vector_angle(rc, dy, dummy);
        su  = (phi + HALF) & 64'hFFFF;
        svs = HALF - 2 * theta;
        if (svs < 0)
            svs = 0;
        if (svs > ONE)
            svs = ONE;
        wm = (w > 1) ? w - 1 : 1;
        hm = (h > 1) ? h - 1 : 1;
        bx = su * wm;
        by = svs * hm;
        t.x0 = int'(bx >> 16);
        t.tx = bx & 64'hFFFF;
        t.y0 = int'(by >> 16);
        t.ty = by & 64'hFFFF;
        if (t.x0 > w - 1)
            t.x0 = w - 1;
        if (t.y0 > h - 1)
            t.y0 = h - 1;
        t.x1 = (t.x0 + 1) % w;
        t.y1 = (t.y0 + 1 < h - 1) ? t.y0 + 1 : h - 1;
        return t;
    endfunction

    function automatic longint texel_chan(int x, int y, int k);
        logic [63:0] v;
        v = image_mem.exists(y * STORE_W + x) ? image_mem[y * STORE_W + x] : 64'd0;
        return longint'((v >> (16 * k)) & 64'hFFFF);
    endfunction

    // Bilinear blend with one half-up rounding at the end
    function automatic eqc_pkg::result_t blend_sample(taps_t t);
        eqc_pkg::result_t res;
        longint           top, bot, total;
        logic [15:0]      ch [4];
        res = '0;
        if (t.flagged)
        begin
            res.status = 1'b1;
            return res;
        end
        for (int k = 0; k < 4; k++)
        begin
            top = texel_chan(t.x0, t.y0, k) * (ONE - t.tx) + texel_chan(t.x1, t.y0, k) * t.tx;
            bot = texel_chan(t.x0, t.y1, k) * (ONE - t.tx) + texel_chan(t.x1, t.y1, k) * t.tx;
            total = top * (ONE - t.ty) + bot * t.ty;
            ch[k] = 16'((total + 64'h8000_0000) >> 32);
        end
        res.sample_red   = ch[0];
        res.sample_green = ch[1];
        res.sample_blue  = ch[2];
        res.sample_alpha = ch[3];
        return res;
    endfunction

    // Clock, cycle limit
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d samples still owed", $time, pending_samples.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Monitor: config and item transactions update the predictor
    always @(posedge clk)
    begin
        eqc_pkg::item_t   acc;
        eqc_pkg::result_t exp_res;
        row_t             hit;
        if (cfg_if.valid && cfg_if.ready)
        begin
            if (cfg_if.data.reg_index == eqc_pkg::REG_SRC_WIDTH)
                width_reg = cfg_if.data.reg_value;
            else
                height_reg = cfg_if.data.reg_value[8:0];
        end
        if (item_if.valid && item_if.ready)
        begin
            acc = item_if.data;
            if (acc.opcode == eqc_pkg::OP_WRITE)
            begin
                n_writes++;
                if (acc.src_col < STORE_W && acc.src_row < STORE_H)
                    image_mem[int'(acc.src_row) * STORE_W + int'(acc.src_col)] =
                        {acc.texel_alpha, acc.texel_blue, acc.texel_green, acc.texel_red};
            end
            else
            begin
                n_requests++;
                if (fixed_samples.size() > 0 && fixed_samples[0].it == acc)
                begin
                    hit = fixed_samples.pop_front();
                    exp_res = hit.want;
                end
                else
                    exp_res = blend_sample(locate(acc.face_sel, acc.face_col, acc.face_row,
                                                  eff_width(), eff_height()));
                if (exp_res.status)
                    n_flagged++;
                pending_samples.push_back(exp_res);
            end
        end
    end

    // Scoreboard: each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        eqc_pkg::result_t got, want;
        if (result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                n_checked++;
                if (got.sample_red !== want.sample_red)
                    $display("%0t: red exp %h got %h", $time, want.sample_red, got.sample_red);
                if (got.sample_green !== want.sample_green)
                    $display("%0t: green exp %h got %h", $time, want.sample_green,
                             got.sample_green);
                if (got.sample_blue !== want.sample_blue)
                    $display("%0t: blue exp %h got %h", $time, want.sample_blue,
                             got.sample_blue);
                if (got.sample_alpha !== want.sample_alpha)
                    $display("%0t: alpha exp %h got %h", $time, want.sample_alpha,
                             got.sample_alpha);
                if (got.status !== want.status)
                    $display("%0t: status exp %b got %b", $time, want.status, got.status);
                if (got !== want)
                    errors++;
            end
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, one long hold-off once traffic is flowing
    always @(posedge clk)
    begin
        if (!hold_done && n_requests >= 300)
        begin
            hold_done <= 1;
            hold_left <= 400;
            result_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_if.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= 1'b1;
            sink_gap <= pick_gap((cycles / 700) % 3 == 0);
        end
    end

    // Sender: one item transaction, then a random gap
    task automatic put_item(eqc_pkg::item_t it);
        int gap;
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic eqc_pkg::item_t rand_item(logic op);
        eqc_pkg::item_t it;
        it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
        it.opcode = op;
        return it;
    endfunction

    function automatic eqc_pkg::item_t texel_write(int col, int row);
        eqc_pkg::item_t it;
        int             r;
        it = rand_item(eqc_pkg::OP_WRITE);
        it.src_col = 9'(col);
        it.src_row = 8'(row);
        r = $urandom_range(9);
        if (r == 0)
            {it.texel_red, it.texel_green, it.texel_blue, it.texel_alpha} = '0;
        else if (r == 1)
            {it.texel_red, it.texel_green, it.texel_blue, it.texel_alpha} = '1;
        return it;
    endfunction

    // Load any unwritten taps first, then issue the request; returns items sent
    task automatic put_request(eqc_pkg::item_t it, output int sent);
        taps_t t;
        int    xs [4];
        int    ys [4];
        sent = 0;
        t = locate(it.face_sel, it.face_col, it.face_row, eff_width(), eff_height());
        if (!t.flagged)
        begin
            xs = '{t.x0, t.x1, t.x0, t.x1};
            ys = '{t.y0, t.y0, t.y1, t.y1};
            for (int k = 0; k < 4; k++)
                if (!loaded.exists(ys[k] * STORE_W + xs[k]))
                begin
                    loaded[ys[k] * STORE_W + xs[k]] = 1;
                    put_item(texel_write(xs[k], ys[k]));
                    sent++;
                end
        end
        put_item(it);
        sent++;
    endtask

    // Register write, only with the pipeline drained
    task automatic set_reg(logic idx, logic [9:0] value);
        item_if.valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{reg_index: idx, reg_value: value};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        // Let the monitor pick up the new size before the next lookup
        @(posedge clk);
    endtask

    task automatic set_source(logic [9:0] w, logic [9:0] h);
        set_reg(eqc_pkg::REG_SRC_WIDTH, w);
        set_reg(eqc_pkg::REG_SRC_HEIGHT, h);
        n_settings++;
    endtask

    function automatic eqc_pkg::item_t req(logic [2:0] face, int col, int row);
        eqc_pkg::item_t it;
        it = rand_item(eqc_pkg::OP_SAMPLE);
        it.face_sel = face;
        it.face_col = 7'(col);
        it.face_row = 7'(row);
        return it;
    endfunction

    function automatic row_t plain(eqc_pkg::item_t it);
        return '{it: it, fixed: 0, want: '0};
    endfunction

    function automatic row_t flagged(eqc_pkg::item_t it);
        return '{it: it, fixed: 1, want: '{default: 0, status: 1'b1}};
    endfunction

    // Main sequence
    initial
    begin
        row_t           directed [];
        logic [9:0]     widths  [8];
        logic [9:0]     heights [8];
        eqc_pkg::item_t it;
        int             sent, count;

        widths  = '{10'd512, 10'd0,   10'd1023, 10'd4,
                    10'd100, 10'd37,  10'd1,    10'd128};
        heights = '{10'd256, 10'd0,   10'd1,    10'd300,
                    10'd37,  10'd100, 10'd511,  10'd64};
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        item_if.valid = 1'b0;
        item_if.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 64x32 source gives a 16-pixel face
        set_source(10'd64, 10'd32);
        directed = '{
            plain(texel_write(0, 0)),
            plain(texel_write(511, 255)),
            plain(texel_write(63, 31)),
            plain(texel_write(0, 31)),
            plain(req(eqc_pkg::FACE_PX, 0, 0)),
            plain(req(eqc_pkg::FACE_NX, 15, 15)),
            plain(req(eqc_pkg::FACE_PY, 7, 7)),
            plain(req(eqc_pkg::FACE_NY, 7, 8)),
            plain(req(eqc_pkg::FACE_PZ, 8, 7)),
            plain(req(eqc_pkg::FACE_NZ, 0, 15)),
            plain(req(3'd6, 15, 0)),
            plain(req(3'd7, 3, 12)),
            plain(req(eqc_pkg::FACE_PY, 0, 0)),
            plain(req(eqc_pkg::FACE_NY, 15, 15)),
            flagged(req(eqc_pkg::FACE_PX, 16, 0)),
            flagged(req(eqc_pkg::FACE_NZ, 0, 16)),
            flagged(req(eqc_pkg::FACE_PZ, 127, 127)),
            flagged(req(3'd7, 127, 0))
        };
        foreach (directed[i])
        begin
            if (directed[i].it.opcode == eqc_pkg::OP_WRITE)
            begin
                loaded[int'(directed[i].it.src_row) * STORE_W +
                       int'(directed[i].it.src_col)] = 1;
                put_item(directed[i].it);
            end
            else if (directed[i].fixed)
            begin
                fixed_samples.push_back(directed[i]);
                put_item(directed[i].it);
            end
            else
                put_request(directed[i].it, sent);
        end

        // Random phases across source sizes, extremes included
        for (int p = 0; p < 8; p++)
        begin
            set_source(widths[p], heights[p]);
            src_calm = (p % 3 == 2);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 30)
                begin
                    it = rand_item(eqc_pkg::OP_WRITE);
                    if (it.src_col < STORE_W && it.src_row < STORE_H)
                        loaded[int'(it.src_row) * STORE_W + int'(it.src_col)] = 1;
                    put_item(it);
                    count++;
                end
                else
                begin
                    it = req(3'($urandom_range(7)), $urandom_range(127), $urandom_range(127));
                    if ($urandom_range(99) < 80)
                    begin
                        it.face_col = 7'($urandom_range(127) % 16 + (p == 0 ? 112 : 0));
                        it.face_row = 7'($urandom_range(15));
                    end
                    put_request(it, sent);
                    count += sent;
                end
            end
        end
        item_if.valid <= 1'b0;

        wait (pending_samples.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d source settings: %0d texel writes, %0d requests", n_settings,
                 n_writes, n_requests);
        $display("%0d results checked, %0d outside the face", n_checked, n_flagged);
        if (errors == 0 && pending_samples.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
